// File: design/gtg_pkg.sv
// Shared types, constants and the arctangent table of the go-to-goal steering block.
`timescale 1ns / 1ps
package gtg_pkg;

	localparam int AngleIter = 16;
	localparam int IterW = (AngleIter > 1) ? $clog2(AngleIter) : 1;
	localparam int CntW = (IterW > 3) ? IterW : 3;

	localparam int CfgW = 21;
	localparam int CfgIdxW = 3;
	localparam int OutW = 22;
	localparam int MulW = 34;
	localparam int ProdW = 2 * MulW;
	localparam int CordW = 52;
	localparam int AngW = 21;

	localparam logic signed [AngW-1:0] PiQ = 21'sd205887;
	localparam logic signed [AngW-1:0] TwoPiQ = 21'sd411774;
	localparam logic signed [AngW-1:0] HalfPiQ = 21'sd102944;
	localparam logic signed [AngW-1:0] ThreeHalfPiQ = 21'sd308832;
	localparam logic signed [CordW-1:0] CordicK = 52'sd652032874;
	localparam logic signed [ProdW-1:0] OutMax = 68'sd2097151;
	localparam logic signed [ProdW-1:0] OutMin = -68'sd2097152;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SPEED_GAIN = 3'd0,
		REG_SPEED_LIMIT = 3'd1,
		REG_ARRIVE_THRESHOLD = 3'd2,
		REG_ARRIVE_TICKS = 3'd3,
		REG_YAW_GAIN = 3'd4,
		REG_YAW_RATE_LIMIT = 3'd5
	} cfg_reg_t;

	typedef enum logic [0:0] {
		REQ_GOAL = 1'b0,
		REQ_TICK = 1'b1
	} req_type_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_GOAL,
		OP_LOAD,
		OP_SQX,
		OP_SQY,
		OP_D2,
		OP_SPLO,
		OP_SPHI,
		OP_SPD,
		OP_QMUL,
		OP_Q1,
		OP_Q2,
		OP_BINIT,
		OP_YINIT,
		OP_STEP,
		OP_BFIN,
		OP_YFIN,
		OP_ERR,
		OP_RMUL,
		OP_RCLP,
		OP_SCINIT,
		OP_SCFIN,
		OP_VXM,
		OP_VYM,
		OP_OUT,
		OP_OUTARR
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_D2,
		S_CHK,
		S_SPLO,
		S_SPHI,
		S_SPD,
		S_QMUL,
		S_Q1,
		S_Q2,
		S_BINIT,
		S_BIT,
		S_BFIN,
		S_YINIT,
		S_YIT,
		S_YFIN,
		S_ERR,
		S_RMUL,
		S_RCLP,
		S_SCINIT,
		S_SCIT,
		S_SCFIN,
		S_VXM,
		S_VYM,
		S_FIN
	} gtg_state_t;

	typedef struct packed {
		dp_op_t op;
		logic [CntW-1:0] cnt;
	} dp_cmd_t;

	typedef struct packed {
		logic close;
		logic [3:0] arrive_ticks;
	} dp_sts_t;

	function automatic logic signed [AngW-1:0] atan_lut(input logic [4:0] idx);
		logic signed [AngW-1:0] r;
		case (idx)
			5'd0: r = 21'sd51472;
			5'd1: r = 21'sd30385;
			5'd2: r = 21'sd16055;
			5'd3: r = 21'sd8150;
			5'd4: r = 21'sd4091;
			5'd5: r = 21'sd2047;
			5'd6: r = 21'sd1024;
			5'd7: r = 21'sd512;
			5'd8: r = 21'sd256;
			5'd9: r = 21'sd128;
			5'd10: r = 21'sd64;
			5'd11: r = 21'sd32;
			5'd12: r = 21'sd16;
			5'd13: r = 21'sd8;
			5'd14: r = 21'sd4;
			5'd15: r = 21'sd2;
			5'd16: r = 21'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: design/gtg_if.sv
// Valid/ready channel interfaces for pose requests and steering results.
`timescale 1ns / 1ps
interface gtg_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic signed [31:0] goal_x;
	logic signed [31:0] goal_y;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;

	modport source(output valid, req_type, goal_x, goal_y, pos_x, pos_y,
		quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink(input valid, req_type, goal_x, goal_y, pos_x, pos_y,
		quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface gtg_rsp_if;
	logic valid;
	logic ready;
	logic signed [21:0] vel_x;
	logic signed [21:0] vel_y;
	logic signed [21:0] yaw_rate;
	logic arrived;

	modport source(output valid, vel_x, vel_y, yaw_rate, arrived, input ready);
	modport sink(input valid, vel_x, vel_y, yaw_rate, arrived, output ready);
endinterface

// File: design/gtg_dp.sv
// Datapath: configuration registers, shared multiplier, CORDIC unit and result registers.
`timescale 1ns / 1ps
module gtg_dp (
	input logic clk,
	input logic arst_n,
	input gtg_pkg::dp_cmd_t cmd,
	output gtg_pkg::dp_sts_t sts,
	input logic cfg_wr_en,
	input logic [gtg_pkg::CfgIdxW-1:0] cfg_index,
	input logic [gtg_pkg::CfgW-1:0] cfg_data,
	input logic signed [31:0] goal_x,
	input logic signed [31:0] goal_y,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic signed [15:0] quat_w,
	output logic signed [gtg_pkg::OutW-1:0] vel_x,
	output logic signed [gtg_pkg::OutW-1:0] vel_y,
	output logic signed [gtg_pkg::OutW-1:0] yaw_rate,
	output logic arrived
);
	localparam int MW = gtg_pkg::MulW;
	localparam int PW = gtg_pkg::ProdW;
	localparam int CW = gtg_pkg::CordW;
	localparam int AW = gtg_pkg::AngW;
	localparam int OutW_l = gtg_pkg::OutW;

	logic [20:0] speed_gain_q, speed_limit_q, arrive_threshold_q, yaw_gain_q, yaw_rate_limit_q;
	logic [3:0] arrive_ticks_q;
	logic signed [31:0] goal_x_q, goal_y_q;

	logic signed [32:0] dx_q, dy_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [31:0] qp_q [8];
	logic [64:0] sx2_q, sy2_q;
	logic [49:0] d2_q;
	logic [41:0] splo_q, sphi_q;
	logic [20:0] speed_q;
	logic signed [MW-1:0] n_q, gim_q, yy_q, yx_q;
	logic yzero_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [AW-1:0] cz_q, base_q, spec_val_q;
	logic vec_q, spec_q, flip_q;
	logic signed [AW-1:0] bearing_q, yaw_q, err_q;
	logic signed [PW-1:0] prod_q;
	logic signed [MW-1:0] c_q, s_q;
	logic signed [OutW_l-1:0] vx_i_q, rate_i_q;
	logic signed [gtg_pkg::OutW-1:0] vel_x_q, vel_y_q, yaw_rate_q;
	logic arrived_q;

	logic signed [MW-1:0] ma, mb;
	logic signed [PW-1:0] prod;
	logic [41:0] d2c;
	logic [65:0] d2_sum;
	logic [62:0] sp_full;
	logic [46:0] sp;
	logic signed [MW-1:0] n_sum, gim_diff, iy, ix, ix_abs;
	logic signed [CW-1:0] sh_x, sh_y;
	logic signed [AW-1:0] tab, zf, zr, err_raw, bearing_adj;
	logic step_pos;
	logic signed [PW-1:0] rate_s, rate_lim, vx_s;
	logic signed [OutW_l-1:0] rate_c, vx_c, vy_c;
	logic [gtg_pkg::IterW-1:0] it;

	assign it = cmd.cnt[gtg_pkg::IterW-1:0];
	assign sts.close = d2_q < {29'b0, arrive_threshold_q};
	assign sts.arrive_ticks = arrive_ticks_q;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			gtg_pkg::OP_SQX: begin
				ma = MW'(dx_q);
				mb = MW'(dx_q);
			end
			gtg_pkg::OP_SQY: begin
				ma = MW'(dy_q);
				mb = MW'(dy_q);
			end
			gtg_pkg::OP_QMUL: begin
				case (cmd.cnt[2:0])
					3'd0: begin ma = MW'(qx_q); mb = MW'(qx_q); end
					3'd1: begin ma = MW'(qy_q); mb = MW'(qy_q); end
					3'd2: begin ma = MW'(qz_q); mb = MW'(qz_q); end
					3'd3: begin ma = MW'(qw_q); mb = MW'(qw_q); end
					3'd4: begin ma = MW'(qx_q); mb = MW'(qz_q); end
					3'd5: begin ma = MW'(qw_q); mb = MW'(qy_q); end
					3'd6: begin ma = MW'(qx_q); mb = MW'(qy_q); end
					default: begin ma = MW'(qw_q); mb = MW'(qz_q); end
				endcase
			end
			gtg_pkg::OP_SPLO: begin
				ma = {13'b0, speed_gain_q};
				mb = {13'b0, d2c[20:0]};
			end
			gtg_pkg::OP_SPHI: begin
				ma = {13'b0, speed_gain_q};
				mb = {13'b0, d2c[41:21]};
			end
			gtg_pkg::OP_RMUL: begin
				ma = {13'b0, yaw_gain_q};
				mb = MW'(err_q);
			end
			gtg_pkg::OP_VXM: begin
				ma = {13'b0, speed_q};
				mb = c_q;
			end
			gtg_pkg::OP_VYM: begin
				ma = {13'b0, speed_q};
				mb = s_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		prod = ma * mb;
	end

	always_comb begin
		if ((|d2_q[49:42]) || (d2_q[41] && (|d2_q[40:0]))) begin
			d2c = {1'b1, 41'b0};
		end else begin
			d2c = d2_q[41:0];
		end
		d2_sum = {1'b0, sx2_q} + {1'b0, sy2_q};
		sp_full = {sphi_q, 21'b0} + {21'b0, splo_q};
		sp = sp_full[62:16];
		n_sum = MW'(qp_q[0]) + MW'(qp_q[1]) + MW'(qp_q[2]) + MW'(qp_q[3]);
		gim_diff = MW'(qp_q[4]) - MW'(qp_q[5]);
	end

	// CORDIC operand selection, rotation direction and angle finish.
	always_comb begin
		if (cmd.op == gtg_pkg::OP_BINIT) begin
			iy = MW'(dy_q);
			ix = MW'(dx_q);
		end else begin
			iy = yy_q;
			ix = yx_q;
		end
		ix_abs = (ix < 0) ? -ix : ix;
		sh_x = cx_q >>> it;
		sh_y = cy_q >>> it;
		tab = gtg_pkg::atan_lut(5'(it));
		step_pos = vec_q ? (cy_q > 0) : (cz_q < 0);
		zf = cz_q + base_q;
		if (zf > gtg_pkg::PiQ) begin
			zf = zf - gtg_pkg::TwoPiQ;
		end
		zr = spec_q ? spec_val_q : zf;
		bearing_adj = (zr < 0) ? zr + gtg_pkg::TwoPiQ : zr;
		err_raw = bearing_q - yaw_q;
	end

	always_comb begin
		rate_s = prod_q >>> 16;
		rate_lim = {{(PW-21){1'b0}}, yaw_rate_limit_q};
		if (rate_s > rate_lim) begin
			rate_c = OutW_l'(rate_lim);
		end else if (rate_s < -rate_lim) begin
			rate_c = OutW_l'(-rate_lim);
		end else begin
			rate_c = OutW_l'(rate_s);
		end
		vx_s = prod_q >>> 30;
		if (vx_s > gtg_pkg::OutMax) begin
			vx_c = OutW_l'(gtg_pkg::OutMax);
		end else if (vx_s < gtg_pkg::OutMin) begin
			vx_c = OutW_l'(gtg_pkg::OutMin);
		end else begin
			vx_c = OutW_l'(vx_s);
		end
		vy_c = vx_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q <= 21'd32768;
			speed_limit_q <= 21'd131072;
			arrive_threshold_q <= 21'd6554;
			arrive_ticks_q <= 4'd3;
			yaw_gain_q <= 21'd65536;
			yaw_rate_limit_q <= 21'd196608;
			goal_x_q <= '0;
			goal_y_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					gtg_pkg::REG_SPEED_GAIN: speed_gain_q <= cfg_data;
					gtg_pkg::REG_SPEED_LIMIT: speed_limit_q <= cfg_data;
					gtg_pkg::REG_ARRIVE_THRESHOLD: arrive_threshold_q <= cfg_data;
					gtg_pkg::REG_ARRIVE_TICKS: arrive_ticks_q <= cfg_data[3:0];
					gtg_pkg::REG_YAW_GAIN: yaw_gain_q <= cfg_data;
					gtg_pkg::REG_YAW_RATE_LIMIT: yaw_rate_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.op == gtg_pkg::OP_GOAL) begin
				goal_x_q <= goal_x;
				goal_y_q <= goal_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			gtg_pkg::OP_LOAD: begin
				dx_q <= 33'(goal_x_q) - 33'(pos_x);
				dy_q <= 33'(goal_y_q) - 33'(pos_y);
				qx_q <= quat_x;
				qy_q <= quat_y;
				qz_q <= quat_z;
				qw_q <= quat_w;
			end
			gtg_pkg::OP_SQX: sx2_q <= prod[64:0];
			gtg_pkg::OP_SQY: sy2_q <= prod[64:0];
			gtg_pkg::OP_D2: d2_q <= d2_sum[65:16];
			gtg_pkg::OP_SPLO: splo_q <= prod[41:0];
			gtg_pkg::OP_SPHI: sphi_q <= prod[41:0];
			gtg_pkg::OP_SPD: speed_q <= (sp > {26'b0, speed_limit_q}) ? speed_limit_q : sp[20:0];
			gtg_pkg::OP_QMUL: qp_q[cmd.cnt[2:0]] <= prod[31:0];
			gtg_pkg::OP_Q1: begin
				n_q <= n_sum;
				gim_q <= (gim_diff < 0) ? -(gim_diff <<< 1) : (gim_diff <<< 1);
			end
			gtg_pkg::OP_Q2: begin
				yy_q <= (MW'(qp_q[6]) + MW'(qp_q[7])) <<< 1;
				yx_q <= n_q - ((MW'(qp_q[1]) + MW'(qp_q[2])) <<< 1);
				yzero_q <= (n_q == '0) || (gim_q >= n_q);
			end
			gtg_pkg::OP_BINIT, gtg_pkg::OP_YINIT: begin
				spec_q <= (iy == '0) || (ix == '0);
				if (iy == '0) begin
					spec_val_q <= (ix < 0) ? gtg_pkg::PiQ : '0;
				end else begin
					spec_val_q <= (iy > 0) ? gtg_pkg::HalfPiQ : -gtg_pkg::HalfPiQ;
				end
				base_q <= (ix < 0) ? gtg_pkg::PiQ : '0;
				cx_q <= CW'(ix_abs) <<< 16;
				cy_q <= ((ix < 0) ? -CW'(iy) : CW'(iy)) <<< 16;
				cz_q <= '0;
				vec_q <= 1'b1;
			end
			gtg_pkg::OP_STEP: begin
				if (step_pos) begin
					cx_q <= cx_q + sh_y;
					cy_q <= cy_q - sh_x;
					cz_q <= cz_q + tab;
				end else begin
					cx_q <= cx_q - sh_y;
					cy_q <= cy_q + sh_x;
					cz_q <= cz_q - tab;
				end
			end
			gtg_pkg::OP_BFIN: bearing_q <= bearing_adj;
			gtg_pkg::OP_YFIN: yaw_q <= yzero_q ? '0 : zr;
			gtg_pkg::OP_ERR: begin
				if (err_raw > gtg_pkg::PiQ) begin
					err_q <= err_raw - gtg_pkg::TwoPiQ;
				end else if (err_raw < -gtg_pkg::PiQ) begin
					err_q <= err_raw + gtg_pkg::TwoPiQ;
				end else begin
					err_q <= err_raw;
				end
			end
			gtg_pkg::OP_RMUL: prod_q <= prod;
			gtg_pkg::OP_RCLP: rate_i_q <= rate_c;
			gtg_pkg::OP_SCINIT: begin
				cx_q <= gtg_pkg::CordicK;
				cy_q <= '0;
				vec_q <= 1'b0;
				if ((bearing_q > gtg_pkg::HalfPiQ) && (bearing_q < gtg_pkg::ThreeHalfPiQ)) begin
					cz_q <= bearing_q - gtg_pkg::PiQ;
					flip_q <= 1'b1;
				end else if (bearing_q >= gtg_pkg::ThreeHalfPiQ) begin
					cz_q <= bearing_q - gtg_pkg::TwoPiQ;
					flip_q <= 1'b0;
				end else begin
					cz_q <= bearing_q;
					flip_q <= 1'b0;
				end
			end
			gtg_pkg::OP_SCFIN: begin
				c_q <= flip_q ? -MW'(cx_q) : MW'(cx_q);
				s_q <= flip_q ? -MW'(cy_q) : MW'(cy_q);
			end
			gtg_pkg::OP_VXM: prod_q <= prod;
			gtg_pkg::OP_VYM: begin
				vx_i_q <= vx_c;
				prod_q <= prod;
			end
			gtg_pkg::OP_OUT: begin
				vel_x_q <= vx_i_q;
				vel_y_q <= vy_c;
				yaw_rate_q <= rate_i_q;
				arrived_q <= 1'b0;
			end
			gtg_pkg::OP_OUTARR: begin
				vel_x_q <= '0;
				vel_y_q <= '0;
				yaw_rate_q <= '0;
				arrived_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign vel_x = vel_x_q;
	assign vel_y = vel_y_q;
	assign yaw_rate = yaw_rate_q;
	assign arrived = arrived_q;

endmodule

// File: design/gtg_ctrl.sv
// Controller: sequences the datapath per request and tracks goal and arrival state.
`timescale 1ns / 1ps
module gtg_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_type,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output gtg_pkg::dp_cmd_t cmd,
	input gtg_pkg::dp_sts_t sts
);
	localparam int CW = gtg_pkg::CntW;
	localparam logic [CW-1:0] IterLast = CW'(gtg_pkg::AngleIter - 1);
	localparam logic [CW-1:0] QuatLast = CW'(7);

	gtg_pkg::gtg_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic active_q, active_d;
	logic [3:0] close_q, close_d;
	logic arr_q, arr_d;
	logic out_valid_q, out_valid_d;
	logic [4:0] close_next;
	logic cnt_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtg_pkg::S_IDLE;
			cnt_q <= '0;
			active_q <= 1'b0;
			close_q <= '0;
			arr_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			active_q <= active_d;
			close_q <= close_d;
			arr_q <= arr_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		active_d = active_q;
		close_d = close_q;
		arr_d = arr_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd.op = gtg_pkg::OP_NONE;
		cmd.cnt = cnt_q;
		in_ready = 1'b0;
		close_next = {1'b0, close_q} + 5'd1;
		cnt_end = 1'b0;

		case (state_q)
			gtg_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cnt_d = '0;
				if (in_valid) begin
					if (in_type == gtg_pkg::REQ_GOAL) begin
						cmd.op = gtg_pkg::OP_GOAL;
						active_d = 1'b1;
					end else if (active_q) begin
						cmd.op = gtg_pkg::OP_LOAD;
						state_d = gtg_pkg::S_SQX;
					end
				end
			end
			gtg_pkg::S_SQX: begin
				cmd.op = gtg_pkg::OP_SQX;
				state_d = gtg_pkg::S_SQY;
			end
			gtg_pkg::S_SQY: begin
				cmd.op = gtg_pkg::OP_SQY;
				state_d = gtg_pkg::S_D2;
			end
			gtg_pkg::S_D2: begin
				cmd.op = gtg_pkg::OP_D2;
				state_d = gtg_pkg::S_CHK;
			end
			gtg_pkg::S_CHK: begin
				arr_d = 1'b0;
				state_d = gtg_pkg::S_SPLO;
				if (sts.close) begin
					if (close_next > {1'b0, sts.arrive_ticks}) begin
						close_d = '0;
						active_d = 1'b0;
						arr_d = 1'b1;
						state_d = gtg_pkg::S_FIN;
					end else begin
						close_d = close_next[3:0];
					end
				end else begin
					close_d = '0;
				end
			end
			gtg_pkg::S_SPLO: begin
				cmd.op = gtg_pkg::OP_SPLO;
				state_d = gtg_pkg::S_SPHI;
			end
			gtg_pkg::S_SPHI: begin
				cmd.op = gtg_pkg::OP_SPHI;
				state_d = gtg_pkg::S_SPD;
			end
			gtg_pkg::S_SPD: begin
				cmd.op = gtg_pkg::OP_SPD;
				state_d = gtg_pkg::S_QMUL;
			end
			gtg_pkg::S_QMUL: begin
				cmd.op = gtg_pkg::OP_QMUL;
				cnt_end = (cnt_q == QuatLast);
				cnt_d = cnt_end ? '0 : cnt_q + 1'b1;
				state_d = cnt_end ? gtg_pkg::S_Q1 : gtg_pkg::S_QMUL;
			end
			gtg_pkg::S_Q1: begin
				cmd.op = gtg_pkg::OP_Q1;
				state_d = gtg_pkg::S_Q2;
			end
			gtg_pkg::S_Q2: begin
				cmd.op = gtg_pkg::OP_Q2;
				state_d = gtg_pkg::S_BINIT;
			end
			gtg_pkg::S_BINIT: begin
				cmd.op = gtg_pkg::OP_BINIT;
				state_d = gtg_pkg::S_BIT;
			end
			gtg_pkg::S_BIT: begin
				cmd.op = gtg_pkg::OP_STEP;
				cnt_end = (cnt_q == IterLast);
				cnt_d = cnt_end ? '0 : cnt_q + 1'b1;
				state_d = cnt_end ? gtg_pkg::S_BFIN : gtg_pkg::S_BIT;
			end
			gtg_pkg::S_BFIN: begin
				cmd.op = gtg_pkg::OP_BFIN;
				state_d = gtg_pkg::S_YINIT;
			end
			gtg_pkg::S_YINIT: begin
				cmd.op = gtg_pkg::OP_YINIT;
				state_d = gtg_pkg::S_YIT;
			end
			gtg_pkg::S_YIT: begin
				cmd.op = gtg_pkg::OP_STEP;
				cnt_end = (cnt_q == IterLast);
				cnt_d = cnt_end ? '0 : cnt_q + 1'b1;
				state_d = cnt_end ? gtg_pkg::S_YFIN : gtg_pkg::S_YIT;
			end
			gtg_pkg::S_YFIN: begin
				cmd.op = gtg_pkg::OP_YFIN;
				state_d = gtg_pkg::S_ERR;
			end
			gtg_pkg::S_ERR: begin
				cmd.op = gtg_pkg::OP_ERR;
				state_d = gtg_pkg::S_RMUL;
			end
			gtg_pkg::S_RMUL: begin
				cmd.op = gtg_pkg::OP_RMUL;
				state_d = gtg_pkg::S_RCLP;
			end
			gtg_pkg::S_RCLP: begin
				cmd.op = gtg_pkg::OP_RCLP;
				state_d = gtg_pkg::S_SCINIT;
			end
			gtg_pkg::S_SCINIT: begin
				cmd.op = gtg_pkg::OP_SCINIT;
				state_d = gtg_pkg::S_SCIT;
			end
			gtg_pkg::S_SCIT: begin
				cmd.op = gtg_pkg::OP_STEP;
				cnt_end = (cnt_q == IterLast);
				cnt_d = cnt_end ? '0 : cnt_q + 1'b1;
				state_d = cnt_end ? gtg_pkg::S_SCFIN : gtg_pkg::S_SCIT;
			end
			gtg_pkg::S_SCFIN: begin
				cmd.op = gtg_pkg::OP_SCFIN;
				state_d = gtg_pkg::S_VXM;
			end
			gtg_pkg::S_VXM: begin
				cmd.op = gtg_pkg::OP_VXM;
				state_d = gtg_pkg::S_VYM;
			end
			gtg_pkg::S_VYM: begin
				cmd.op = gtg_pkg::OP_VYM;
				state_d = gtg_pkg::S_FIN;
			end
			gtg_pkg::S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = arr_q ? gtg_pkg::OP_OUTARR : gtg_pkg::OP_OUT;
					out_valid_d = 1'b1;
					state_d = gtg_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gtg_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/go_to_goal_steering.sv
// Top level of the proportional go-to-goal steering controller.
//
// Requests arrive on the req channel. A goal request stores the goal and arms
// the controller as it is taken and gives no result. A pose tick while
// disarmed is taken and gives no result. A pose tick while armed gives one
// result on the rsp channel: ground velocity, yaw rate and the arrival flag.
// An armed tick runs the distance, speed, attitude, bearing, yaw, rate and
// velocity steps; an arrival tick goes from the distance check to the result.
// The pace is set by the three passes of the single shared CORDIC unit and
// the single shared multiplier, which handles one product per cycle.
// One request is in work at a time; req.ready is high only between requests.
// The result sits in an output register, so the next request is taken while
// a result waits; a stalled receiver holds the block at its final step.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user
// must write them while the block is idle, which it does not enforce. Reset
// loads register defaults and clears the goal, close count and armed state.
`timescale 1ns / 1ps
module go_to_goal_steering (
	input logic clk,
	input logic arst_n,
	gtg_req_if.sink req,
	gtg_rsp_if.source rsp,
	input logic cfg_wr_en,
	input logic [gtg_pkg::CfgIdxW-1:0] cfg_index,
	input logic [gtg_pkg::CfgW-1:0] cfg_data
);
	gtg_pkg::dp_cmd_t cmd;
	gtg_pkg::dp_sts_t sts;

	gtg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_type(req.req_type),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd(cmd),
		.sts(sts)
	);

	gtg_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.goal_x(req.goal_x),
		.goal_y(req.goal_y),
		.pos_x(req.pos_x),
		.pos_y(req.pos_y),
		.quat_x(req.quat_x),
		.quat_y(req.quat_y),
		.quat_z(req.quat_z),
		.quat_w(req.quat_w),
		.vel_x(rsp.vel_x),
		.vel_y(rsp.vel_y),
		.yaw_rate(rsp.yaw_rate),
		.arrived(rsp.arrived)
	);

endmodule

// File: design/gtg_chk.sv
// Port-level assertions for the go-to-goal steering block and their binding.
`timescale 1ns / 1ps
module gtg_chk (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic signed [21:0] vel_x,
	input logic signed [21:0] vel_y,
	input logic signed [21:0] yaw_rate,
	input logic arrived
);
	// The block only leaves the ready state after a transfer.
	a_ready_holds: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready && !req_valid |=> req_ready)
		else $error("request ready dropped without a transfer");

	// An arrival result carries zero commands.
	a_arrival_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && arrived |-> vel_x == '0 && vel_y == '0 && yaw_rate == '0)
		else $error("arrival result carries nonzero commands");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(vel_x) && $stable(vel_y)
		&& $stable(yaw_rate) && $stable(arrived))
		else $error("stalled result changed");

endmodule

bind go_to_goal_steering gtg_chk u_gtg_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.vel_x(rsp.vel_x),
	.vel_y(rsp.vel_y),
	.yaw_rate(rsp.yaw_rate),
	.arrived(rsp.arrived)
);

// File: tb/sv/tb_go_to_goal_steering.sv
// Self-checking testbench for the go-to-goal steering block: directed and random requests.
`timescale 1ns / 1ps
module tb_go_to_goal_steering;

	localparam int ITERS = gtg_pkg::AngleIter;
	localparam longint ANG_PI = 205887;
	localparam longint ANG_2PI = 411774;
	localparam longint ANG_HALF = 102944;
	localparam longint GAIN_K = 652032874;
	localparam longint VEL_MAX = 2097151;
	localparam longint VEL_MIN = -2097152;

	typedef struct {
		gtg_pkg::req_type_t rt;
		int gx, gy, px, py;
		shortint qx, qy, qz, qw;
	} req_item_t;

	typedef struct {
		logic signed [21:0] vx, vy, yr;
		logic arr;
	} steer_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [gtg_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [gtg_pkg::CfgW-1:0] cfg_data = '0;

	gtg_req_if req_ch();
	gtg_rsp_if rsp_ch();

	go_to_goal_steering u_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	longint atan_rom [0:23] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
		64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

	longint m_sgain, m_slim, m_thr, m_ticks, m_ygain, m_ylim;
	longint m_gx, m_gy, m_close;
	bit m_armed;

	steer_cmd_t steer_q[$];
	int mismatch_cnt = 0;
	int burst_left = 0;
	int hold_left = 0;
	int pat_left = 0;
	int pat_mode = 0;

	function automatic longint atan2_q(longint y, longint x);
		longint z, base, nx, ny;
		z = 0;
		base = 0;
		if (y == 0) return (x < 0) ? ANG_PI : 0;
		if (x == 0) return (y > 0) ? ANG_HALF : -ANG_HALF;
		if (x < 0) begin
			x = -x;
			y = -y;
			base = ANG_PI;
		end
		x = x * 65536;
		y = y * 65536;
		for (int i = 0; i < ITERS && i < 24; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += atan_rom[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= atan_rom[i];
			end
			x = nx;
			y = ny;
		end
		z += base;
		if (z > ANG_PI) z -= ANG_2PI;
		return z;
	endfunction

	task automatic sincos_q(input longint a, output longint c, output longint s);
		longint x, y, z, nx, ny;
		bit flip;
		x = GAIN_K;
		y = 0;
		z = a;
		flip = 0;
		if (z > ANG_HALF && z < 3 * ANG_HALF) begin
			z -= ANG_PI;
			flip = 1;
		end else if (z >= 3 * ANG_HALF) begin
			z -= ANG_2PI;
		end
		for (int i = 0; i < ITERS && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= atan_rom[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += atan_rom[i];
			end
			x = nx;
			y = ny;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic steer_predict(input req_item_t it);
		longint dx, dy, bearing, yaw, err, rate, spd, c, s, n, gim, qx, qy, qz, qw;
		longint unsigned ax, ay, sx2, sy2, d2, d2c, sp;
		steer_cmd_t cmd;
		if (it.rt == gtg_pkg::REQ_GOAL) begin
			m_gx = longint'(it.gx);
			m_gy = longint'(it.gy);
			m_armed = 1;
			return;
		end
		if (!m_armed) return;
		dx = m_gx - longint'(it.px);
		dy = m_gy - longint'(it.py);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sx2 = ax * ax;
		sy2 = ay * ay;
		d2 = (sx2 >> 16) + (sy2 >> 16) + (((sx2 & 64'hFFFF) + (sy2 & 64'hFFFF)) >> 16);
		if (d2 < longint'(m_thr)) begin
			if (m_close + 1 > m_ticks) begin
				m_close = 0;
				m_armed = 0;
				cmd.vx = '0;
				cmd.vy = '0;
				cmd.yr = '0;
				cmd.arr = 1'b1;
				steer_q = {steer_q, cmd};
				return;
			end
			m_close = (m_close + 1) & 15;
		end else begin
			m_close = 0;
		end
		d2c = (d2 > (64'd1 << 41)) ? (64'd1 << 41) : d2;
		sp = (longint'(m_sgain) * d2c) >> 16;
		if (sp > m_slim) sp = m_slim;
		spd = sp;
		bearing = atan2_q(dy, dx);
		if (bearing < 0) bearing += ANG_2PI;
		qx = longint'(it.qx);
		qy = longint'(it.qy);
		qz = longint'(it.qz);
		qw = longint'(it.qw);
		n = qx * qx + qy * qy + qz * qz + qw * qw;
		gim = 2 * (qx * qz - qw * qy);
		if (gim < 0) gim = -gim;
		if (n == 0 || gim >= n) yaw = 0;
		else yaw = atan2_q(2 * (qx * qy + qw * qz), n - 2 * (qy * qy + qz * qz));
		err = bearing - yaw;
		if (err > ANG_PI) err -= ANG_2PI;
		else if (err < -ANG_PI) err += ANG_2PI;
		rate = clip((m_ygain * err) >>> 16, -m_ylim, m_ylim);
		sincos_q(bearing, c, s);
		cmd.vx = 22'(clip((spd * c) >>> 30, VEL_MIN, VEL_MAX));
		cmd.vy = 22'(clip((spd * s) >>> 30, VEL_MIN, VEL_MAX));
		cmd.yr = 22'(rate);
		cmd.arr = 1'b0;
		steer_q = {steer_q, cmd};
	endtask

	// Receiver: long hold-offs on request, otherwise a changing stall pattern.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			if (pat_left == 0) begin
				pat_mode = $urandom_range(2);
				pat_left = $urandom_range(50, 300);
			end
			pat_left--;
			case (pat_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(3) != 0);
				default: rsp_ch.ready <= ($urandom_range(1) == 1);
			endcase
		end
	end

	always @(posedge clk) begin
		steer_cmd_t exp_cmd;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (steer_q.size() == 0) begin
				$display("%0t: unexpected result vx=%0d vy=%0d yr=%0d arr=%0b", $time,
					rsp_ch.vel_x, rsp_ch.vel_y, rsp_ch.yaw_rate, rsp_ch.arrived);
				mismatch_cnt++;
			end else begin
				exp_cmd = steer_q.pop_front();
				if (exp_cmd.vx !== rsp_ch.vel_x || exp_cmd.vy !== rsp_ch.vel_y ||
						exp_cmd.yr !== rsp_ch.yaw_rate || exp_cmd.arr !== rsp_ch.arrived) begin
					$display("%0t: mismatch expected vx=%0d vy=%0d yr=%0d arr=%0b", $time,
						exp_cmd.vx, exp_cmd.vy, exp_cmd.yr, exp_cmd.arr);
					$display("%0t:          actual   vx=%0d vy=%0d yr=%0d arr=%0b", $time,
						rsp_ch.vel_x, rsp_ch.vel_y, rsp_ch.yaw_rate, rsp_ch.arrived);
					mismatch_cnt++;
				end
			end
		end
	end

	task automatic send_item(input req_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.rt;
		req_ch.goal_x <= it.gx;
		req_ch.goal_y <= it.gy;
		req_ch.pos_x <= it.px;
		req_ch.pos_y <= it.py;
		req_ch.quat_x <= it.qx;
		req_ch.quat_y <= it.qy;
		req_ch.quat_z <= it.qz;
		req_ch.quat_w <= it.qw;
		do @(posedge clk); while (!req_ch.ready);
		steer_predict(it);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (steer_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic cfg_write(input gtg_pkg::cfg_reg_t r, input longint v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v[gtg_pkg::CfgW-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (r)
			gtg_pkg::REG_SPEED_GAIN: m_sgain = v & 21'h1FFFFF;
			gtg_pkg::REG_SPEED_LIMIT: m_slim = v & 21'h1FFFFF;
			gtg_pkg::REG_ARRIVE_THRESHOLD: m_thr = v & 21'h1FFFFF;
			gtg_pkg::REG_ARRIVE_TICKS: m_ticks = v & 15;
			gtg_pkg::REG_YAW_GAIN: m_ygain = v & 21'h1FFFFF;
			default: m_ylim = v & 21'h1FFFFF;
		endcase
	endtask

	task automatic cfg_all(input longint sg, sl, th, tk, yg, yl);
		cfg_write(gtg_pkg::REG_SPEED_GAIN, sg);
		cfg_write(gtg_pkg::REG_SPEED_LIMIT, sl);
		cfg_write(gtg_pkg::REG_ARRIVE_THRESHOLD, th);
		cfg_write(gtg_pkg::REG_ARRIVE_TICKS, tk);
		cfg_write(gtg_pkg::REG_YAW_GAIN, yg);
		cfg_write(gtg_pkg::REG_YAW_RATE_LIMIT, yl);
	endtask

	function automatic req_item_t mk_goal(int gx, int gy);
		req_item_t it;
		it.rt = gtg_pkg::REQ_GOAL;
		it.gx = gx;
		it.gy = gy;
		it.px = $urandom;
		it.py = $urandom;
		it.qx = shortint'($urandom);
		it.qy = shortint'($urandom);
		it.qz = shortint'($urandom);
		it.qw = shortint'($urandom);
		return it;
	endfunction

	function automatic req_item_t mk_tick(int px, int py, shortint qx, qy, qz, qw);
		req_item_t it;
		it.rt = gtg_pkg::REQ_TICK;
		it.gx = $urandom;
		it.gy = $urandom;
		it.px = px;
		it.py = py;
		it.qx = qx;
		it.qy = qy;
		it.qz = qz;
		it.qw = qw;
		return it;
	endfunction

	function automatic shortint rand_quat();
		return shortint'($urandom_range(32768)) - 16'sd16384;
	endfunction

	function automatic req_item_t rand_item();
		int pick, sc, ox, oy;
		pick = $urandom_range(99);
		if (pick < 8) begin
			if ($urandom_range(1)) return mk_goal($urandom, $urandom);
			return mk_goal($urandom_range(1 << 20) - (1 << 19), $urandom_range(1 << 20) - (1 << 19));
		end
		if (pick < 75) begin
			sc = $urandom_range(20);
			ox = $urandom_range((1 << sc) * 2) - (1 << sc);
			oy = $urandom_range((1 << sc) * 2) - (1 << sc);
			return mk_tick(int'(m_gx) - ox, int'(m_gy) - oy,
				rand_quat(), rand_quat(), rand_quat(), rand_quat());
		end
		return mk_tick($urandom, $urandom, rand_quat(), rand_quat(), rand_quat(), rand_quat());
	endfunction

	task automatic test_directed();
		send_item(mk_tick(0, 0, 0, 0, 0, 16384));
		send_item(mk_goal(0, 0));
		send_item(mk_tick(-196608, 0, 0, 0, 0, 16384));
		send_item(mk_tick(196608, 0, 0, 0, 16384, 0));
		send_item(mk_tick(0, -131072, 16384, 16384, 16384, 16384));
		send_item(mk_tick(0, 131072, 0, 0, 0, 0));
		send_item(mk_tick(-5000000, 7000000, 0, 16384, 0, 16384));
		send_item(mk_tick(0, 0, 3, -2, 1, 5));
		send_item(mk_goal(32'sh7FFFFFFF, 32'sh7FFFFFFF));
		send_item(mk_tick(32'sh80000000, 32'sh80000000, -16384, -16384, -16384, -16384));
		send_item(mk_goal(32'sh80000000, 32'sh7FFFFFFF));
		send_item(mk_tick(32'sh7FFFFFFF, 32'sh80000000, 16384, -16384, 16384, -16384));
		send_item(mk_goal(1000, -1000));
		repeat (4) send_item(mk_tick(1000, -1000, 0, 0, 8000, 14000));
		send_item(mk_tick(1000, -1000, 0, 0, 0, 16384));
		drain_results();
	endtask

	task automatic test_random_phase(input int n_items);
		for (int i = 0; i < n_items; i++) send_item(rand_item());
		drain_results();
	endtask

	task automatic test_backpressure();
		send_item(mk_goal($urandom, $urandom));
		@(negedge clk);
		req_ch.valid <= 1'b0;
		hold_left = 400;
		for (int i = 0; i < 20; i++)
			send_item(mk_tick($urandom, $urandom, rand_quat(), rand_quat(), rand_quat(),
				rand_quat()));
		drain_results();
	endtask

	task automatic test_pause();
		for (int i = 0; i < 30; i++) send_item(rand_item());
		drain_results();
		for (int i = 0; i < 30; i++) send_item(rand_item());
		drain_results();
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = gtg_pkg::REQ_GOAL;
		req_ch.goal_x = 0;
		req_ch.goal_y = 0;
		req_ch.pos_x = 0;
		req_ch.pos_y = 0;
		req_ch.quat_x = 0;
		req_ch.quat_y = 0;
		req_ch.quat_z = 0;
		req_ch.quat_w = 0;
		m_sgain = 32768;
		m_slim = 131072;
		m_thr = 6554;
		m_ticks = 3;
		m_ygain = 65536;
		m_ylim = 196608;
		m_gx = 0;
		m_gy = 0;
		m_armed = 0;
		m_close = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(130);
		cfg_all(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 15, 21'h1FFFFF, 21'h1FFFFF);
		test_random_phase(130);
		cfg_all(0, 0, 0, 0, 0, 0);
		test_random_phase(100);
		cfg_all(1048576, 1048576, 1048576, 0, 1048576, 1048576);
		test_random_phase(130);
		cfg_all($urandom_range(1 << 21), $urandom_range(1 << 21), $urandom_range(1 << 18),
			$urandom_range(15), $urandom_range(1 << 21), $urandom_range(1 << 21));
		test_random_phase(130);
		cfg_all(32768, 131072, 6554, 3, 65536, 196608);
		test_backpressure();
		test_pause();
		test_random_phase(100);

		if (mismatch_cnt == 0 && steer_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
